FILE: hw/rtl/deqs_pkg.sv
package deqs_pkg;

  localparam int DATA_W = 32;
  localparam int DEPTH_DEFAULT = 16;
  localparam int COUNT_OUT_W = 5;
  localparam int REQ_W = 3;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd5;

  localparam logic [2:0] CMD_HOLD       = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
  localparam logic [2:0] CMD_SHIFT      = 3'd3;
  localparam logic [2:0] CMD_ROTATE     = 3'd4;

  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] val;
  } cell_cmd_t;

endpackage

FILE: hw/rtl/deqs_cell.sv
module deqs_cell #(
  parameter int DEPTH = deqs_pkg::DEPTH_DEFAULT,
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  deqs_pkg::cell_cmd_t                 cmd,
  input  logic [$clog2(DEPTH+1)-1:0]          cnt,
  input  logic signed [deqs_pkg::DATA_W-1:0]  prev_q,
  input  logic signed [deqs_pkg::DATA_W-1:0]  next_q,
  input  logic signed [deqs_pkg::DATA_W-1:0]  front_q,
  output logic signed [deqs_pkg::DATA_W-1:0]  q
);

  localparam int CW = $clog2(DEPTH+1);

  logic at_tail;
  logic at_last;

  assign at_tail = (cnt == CW'(IDX));
  assign at_last = (cnt == CW'(IDX + 1));

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      deqs_pkg::CMD_PUSH_FRONT: begin
        q <= (IDX == 0) ? cmd.val : prev_q;
      end
      deqs_pkg::CMD_PUSH_BACK: begin
        if (at_tail) begin
          q <= cmd.val;
        end
      end
      deqs_pkg::CMD_SHIFT: begin
        q <= next_q;
      end
      deqs_pkg::CMD_ROTATE: begin
        q <= at_last ? front_q : next_q;
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule

FILE: hw/rtl/double_ended_queue_with_search.sv
// Bounded double-ended queue of signed 32-bit values held in a row of DEPTH cells, front in
// cell 0. Pushes and pops at either end need no scan, and a new item can be accepted in the
// same cycle that the last result is taken. Delete and search rotate the stored entries through
// the row once, comparing the front cell against the key on each step; the rotation restores the
// original order, minus the deleted entry. Each item gives exactly one result item.
module double_ended_queue_with_search #(
  parameter int DEPTH = deqs_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] data_in
  input  logic [7:0]  s_axis_tuser,  // [2:0] req_type, [7:3] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // [31:0] data_out, [36:32] entry_count, [39:37] zero
  output logic [7:0]  m_axis_tuser   // [0] ok, [7:1] zero
);

  localparam int CW = $clog2(DEPTH+1);
  localparam int AW = $clog2(DEPTH);
  localparam int DW = deqs_pkg::DATA_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                 state;
  logic                 state_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic [CW-1:0]        scan_left;
  logic [CW-1:0]        scan_left_next;
  logic                 found;
  logic                 found_next;
  logic                 is_delete;
  logic signed [DW-1:0] key;

  logic                 out_valid;
  logic                 out_ok;
  logic signed [DW-1:0] out_data;
  logic [CW-1:0]        out_count;

  logic                 res_load;
  logic                 res_ok;
  logic signed [DW-1:0] res_data;

  logic                 accept;
  logic [2:0]           req;
  logic signed [DW-1:0] din;
  logic                 front_match;
  logic [AW-1:0]        back_idx;

  deqs_pkg::cell_cmd_t  cmd;
  logic signed [DW-1:0] cell_q [DEPTH];

  assign req = s_axis_tuser[2:0];
  assign din = s_axis_tdata;
  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign front_match = !found && (cell_q[0] == key);
  assign back_idx = AW'(count - CW'(1));

  always_comb begin
    state_next = state;
    count_next = count;
    scan_left_next = scan_left;
    found_next = found;
    res_load = 1'b0;
    res_ok = 1'b0;
    res_data = '0;
    cmd.op = deqs_pkg::CMD_HOLD;
    cmd.val = din;
    if (state == ST_IDLE) begin
      if (accept) begin
        res_load = 1'b1;
        unique case (req) inside
          deqs_pkg::REQ_PUSH_FRONT, deqs_pkg::REQ_PUSH_BACK: begin
            if (count < CW'(DEPTH)) begin
              cmd.op = (req == deqs_pkg::REQ_PUSH_FRONT) ? deqs_pkg::CMD_PUSH_FRONT
                                                         : deqs_pkg::CMD_PUSH_BACK;
              count_next = count + CW'(1);
              res_ok = 1'b1;
            end
          end
          deqs_pkg::REQ_POP_FRONT: begin
            if (count != '0) begin
              cmd.op = deqs_pkg::CMD_SHIFT;
              res_data = cell_q[0];
              count_next = count - CW'(1);
              res_ok = 1'b1;
            end
          end
          deqs_pkg::REQ_POP_BACK: begin
            if (count != '0) begin
              res_data = cell_q[back_idx];
              count_next = count - CW'(1);
              res_ok = 1'b1;
            end
          end
          deqs_pkg::REQ_DELETE, deqs_pkg::REQ_SEARCH: begin
            if (count != '0) begin
              res_load = 1'b0;
              state_next = ST_SCAN;
              scan_left_next = count;
              found_next = 1'b0;
            end
          end
          default: begin
            res_ok = 1'b0;
          end
        endcase
      end
    end else begin
      cmd.val = key;
      if (is_delete && front_match) begin
        cmd.op = deqs_pkg::CMD_SHIFT;
        count_next = count - CW'(1);
      end else begin
        cmd.op = deqs_pkg::CMD_ROTATE;
      end
      found_next = found || front_match;
      scan_left_next = scan_left - CW'(1);
      if (scan_left == CW'(1)) begin
        state_next = ST_IDLE;
        res_load = 1'b1;
        res_ok = found || front_match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_left <= scan_left_next;
    found <= found_next;
    if (accept) begin
      key <= din;
      is_delete <= (req == deqs_pkg::REQ_DELETE);
    end
    if (res_load) begin
      out_ok <= res_ok;
      out_data <= res_data;
      out_count <= count_next;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DW-1:0] prev_q;
    logic signed [DW-1:0] next_q;
    if (i == 0) begin : g_first
      assign prev_q = cmd.val;
    end else begin : g_mid_prev
      assign prev_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_q = '0;
    end else begin : g_mid_next
      assign next_q = cell_q[i+1];
    end
    deqs_cell #(
      .DEPTH(DEPTH),
      .IDX(i)
    ) u_cell (
      .clk(clk),
      .cmd(cmd),
      .cnt(count),
      .prev_q(prev_q),
      .next_q(next_q),
      .front_q(cell_q[0]),
      .q(cell_q[i])
    );
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {3'b000, deqs_pkg::COUNT_OUT_W'(out_count), out_data};
  assign m_axis_tuser = {7'b0000000, out_ok};

endmodule
